[rtl/core/lagalloc_pkg.sv]
`timescale 1ns / 1ps
package lagalloc_pkg;
  localparam int MaxEntries = 32;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int BytesW = 40;

  typedef struct packed {
    logic        is_image;
    logic [3:0]  kind;
    logic [39:0] byte_size;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] pixel_format;
    logic [6:0]  samples;
    logic [11:0] first_use;
    logic [11:0] last_use;
    logic        final_decl;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  res_index;
    logic [4:0]  group_index;
    logic [39:0] group_bytes;
    logic        last_result;
    logic        dropped_any;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] fmt;
    logic [11:0] last_use;
    logic [11:0] first_use;
  } attrs_t;

  typedef struct packed {
    logic [BytesW-1:0] bytes;
    attrs_t            attrs;
    logic [31:0]       dims;
  } entry_t;

  typedef struct packed {
    logic        enable_aliasing;
    logic        require_same_type;
    logic        require_same_format;
    logic        require_same_dims;
    logic [39:0] min_share_bytes;
  } cfg_t;

  typedef enum logic [3:0] {
    StLoad, StMul1, StMul2, StPick, StPickRd, StGrp, StScan, StScanRd,
    StPlace, StOutRd, StOutGrp, StOut, StWait
  } state_e;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegType   = 3'd1;
  localparam logic [2:0] RegFormat = 3'd2;
  localparam logic [2:0] RegDims   = 3'd3;
  localparam logic [2:0] RegMin    = 3'd4;
endpackage

[rtl/core/lagalloc_cfg.sv]
`timescale 1ns / 1ps
module lagalloc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output lagalloc_pkg::cfg_t  cfg_o
);
  lagalloc_pkg::cfg_t cfg_q;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[5:3];
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable_aliasing: 1'b1, require_same_type: 1'b1,
                 require_same_format: 1'b0, require_same_dims: 1'b0,
                 min_share_bytes: '0};
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        lagalloc_pkg::RegEnable: cfg_q.enable_aliasing <= pwdata[0];
        lagalloc_pkg::RegType:   cfg_q.require_same_type <= pwdata[0];
        lagalloc_pkg::RegFormat: cfg_q.require_same_format <= pwdata[0];
        lagalloc_pkg::RegDims:   cfg_q.require_same_dims <= pwdata[0];
        lagalloc_pkg::RegMin:    cfg_q.min_share_bytes <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      lagalloc_pkg::RegEnable: prdata[0] = cfg_q.enable_aliasing;
      lagalloc_pkg::RegType:   prdata[0] = cfg_q.require_same_type;
      lagalloc_pkg::RegFormat: prdata[0] = cfg_q.require_same_format;
      lagalloc_pkg::RegDims:   prdata[0] = cfg_q.require_same_dims;
      lagalloc_pkg::RegMin:    prdata[39:0] = cfg_q.min_share_bytes;
      default: prdata = '0;
    endcase
  end
endmodule

[rtl/core/lagalloc_core.sv]
`timescale 1ns / 1ps
module lagalloc_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lagalloc_pkg::cfg_t      cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lagalloc_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lagalloc_pkg::out_word_t out_data_o
);
  localparam int IW = lagalloc_pkg::IdxW;
  localparam int CW = lagalloc_pkg::CntW;
  localparam int BW = lagalloc_pkg::BytesW;
  localparam int ME = lagalloc_pkg::MaxEntries;

  // entry store and group store, with registered reads
  lagalloc_pkg::entry_t ent_mem [ME];
  logic [IW-1:0]        grp_mem [ME];
  logic [BW-1:0]        gmax_mem [ME];

  lagalloc_pkg::state_e st_q, st_d;
  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic          fin_q;
  lagalloc_pkg::in_word_t inw_q;
  logic [33:0]   prod1_q;
  logic [ME-1:0] visited_q;
  logic [CW-1:0] i_q;
  logic [CW-1:0] k_q;
  logic [CW-1:0] groups_q;
  logic [CW-1:0] best_q;
  logic [BW-1:0] best_bytes_q;
  lagalloc_pkg::entry_t best_ent_q;
  logic [CW-1:0] g_q;
  logic          ok_q;
  lagalloc_pkg::entry_t rd_ent_q;
  logic [IW-1:0] rd_grp_q;
  logic [BW-1:0] rd_gmax_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] gmax_addr;
  lagalloc_pkg::out_word_t out_q;
  logic          out_v_q;

  // memory reads
  always_ff @(posedge clk_i) begin
    rd_ent_q  <= ent_mem[rd_addr];
    rd_grp_q  <= grp_mem[rd_addr];
    rd_gmax_q <= gmax_mem[gmax_addr];
  end

  logic [IW-1:0] cnt_idx;
  assign cnt_idx = cnt_q[IW-1:0];

  // scan loops fetch the next entry so its word is ready when i_q gets there
  // output reads the entry's group first, then that group's size
  always_comb begin
    if (st_q == lagalloc_pkg::StPickRd || st_q == lagalloc_pkg::StScanRd)
      rd_addr = i_q[IW-1:0] + IW'(1);
    else
      rd_addr = i_q[IW-1:0];
    gmax_addr = (st_q == lagalloc_pkg::StOutGrp) ? rd_grp_q : g_q[IW-1:0];
  end

  // entry i compared against best
  logic overlap, compat, last_n;
  always_comb begin
    overlap = !((best_ent_q.attrs.last_use < rd_ent_q.attrs.first_use) ||
                (rd_ent_q.attrs.last_use < best_ent_q.attrs.first_use));
    compat = 1'b1;
    if (cfg_i.require_same_type && best_ent_q.attrs.kind != rd_ent_q.attrs.kind) compat = 1'b0;
    if (cfg_i.require_same_format && best_ent_q.attrs.fmt != rd_ent_q.attrs.fmt) compat = 1'b0;
    if (cfg_i.require_same_dims && best_ent_q.dims != rd_ent_q.dims) compat = 1'b0;
    if (best_ent_q.bytes < cfg_i.min_share_bytes || rd_ent_q.bytes < cfg_i.min_share_bytes)
      compat = 1'b0;
    last_n = (i_q + 1'b1 == cnt_q);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      lagalloc_pkg::StLoad:
        if (in_valid_i) st_d = lagalloc_pkg::StMul1;
      lagalloc_pkg::StMul1: st_d = lagalloc_pkg::StMul2;
      lagalloc_pkg::StMul2:
        if (!fin_q) st_d = lagalloc_pkg::StLoad;
        else st_d = cfg_i.enable_aliasing ? lagalloc_pkg::StPick : lagalloc_pkg::StOutRd;
      lagalloc_pkg::StPick: st_d = lagalloc_pkg::StPickRd;
      lagalloc_pkg::StPickRd:
        if (last_n) st_d = lagalloc_pkg::StGrp;
      lagalloc_pkg::StGrp:
        st_d = (g_q == groups_q) ? lagalloc_pkg::StPlace : lagalloc_pkg::StScan;
      lagalloc_pkg::StScan: st_d = lagalloc_pkg::StScanRd;
      lagalloc_pkg::StScanRd:
        if (last_n) st_d = lagalloc_pkg::StPlace;
      lagalloc_pkg::StPlace:
        if (!ok_q && g_q != groups_q) st_d = lagalloc_pkg::StGrp;
        else if (k_q + 1'b1 == cnt_q) st_d = lagalloc_pkg::StOutRd;
        else st_d = lagalloc_pkg::StPick;
      lagalloc_pkg::StOutRd: st_d = lagalloc_pkg::StOutGrp;
      lagalloc_pkg::StOutGrp: st_d = lagalloc_pkg::StOut;
      lagalloc_pkg::StOut: st_d = lagalloc_pkg::StWait;
      lagalloc_pkg::StWait:
        if (!out_v_q || !out_stall_i)
          st_d = last_n ? lagalloc_pkg::StLoad : lagalloc_pkg::StOutRd;
      default: st_d = lagalloc_pkg::StLoad;
    endcase
  end

  assign in_stall_o = (st_q != lagalloc_pkg::StLoad);
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    case (st_q)
      lagalloc_pkg::StLoad: inw_q <= in_data_i;
      lagalloc_pkg::StMul1: prod1_q <= {inw_q.img_width, 2'b00} * inw_q.img_height;
      default: ;
    endcase
  end

  // second multiply feeds the store write directly, saturating image size
  logic [40:0] p2c;
  logic [BW-1:0] wr_bytes;
  always_comb begin
    p2c = 41'(prod1_q) * 41'(inw_q.samples);
    if (!inw_q.is_image) wr_bytes = inw_q.byte_size;
    else if (p2c[40]) wr_bytes = '1;
    else wr_bytes = p2c[39:0];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == lagalloc_pkg::StMul2 && cnt_q < CW'(ME)) begin
      ent_mem[cnt_idx].bytes <= wr_bytes;
      ent_mem[cnt_idx].attrs <= '{kind: inw_q.kind,
                                  fmt: inw_q.is_image ? inw_q.pixel_format : 16'd0,
                                  last_use: inw_q.last_use, first_use: inw_q.first_use};
      ent_mem[cnt_idx].dims <= inw_q.is_image ? {inw_q.img_height, inw_q.img_width} : 32'd0;
    end
    if (st_q == lagalloc_pkg::StPlace && (ok_q || g_q == groups_q)) begin
      grp_mem[best_q[IW-1:0]] <= g_q[IW-1:0];
      if (g_q == groups_q || best_bytes_q > rd_gmax_q)
        gmax_mem[g_q[IW-1:0]] <= best_bytes_q;
    end
    if (st_q == lagalloc_pkg::StOutRd && !cfg_i.enable_aliasing) begin
      grp_mem[i_q[IW-1:0]] <= i_q[IW-1:0];
    end
  end

  // no-alias output uses entry bytes directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lagalloc_pkg::StLoad;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      fin_q <= 1'b0;
      out_v_q <= 1'b0;
      out_q <= '0;
      visited_q <= '0;
      i_q <= '0;
      k_q <= '0;
      groups_q <= '0;
      best_q <= '0;
      best_bytes_q <= '0;
      best_ent_q <= '0;
      g_q <= '0;
      ok_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        lagalloc_pkg::StLoad: begin
          fin_q <= in_data_i.final_decl;
          i_q <= '0;
        end
        lagalloc_pkg::StMul2: begin
          if (cnt_q < CW'(ME)) cnt_q <= cnt_q + 1'b1;
          else ovf_q <= 1'b1;
          visited_q <= '0;
          k_q <= '0;
          groups_q <= '0;
          i_q <= '0;
          best_q <= CW'(ME);
        end
        lagalloc_pkg::StPick: i_q <= '0;
        lagalloc_pkg::StPickRd: begin
          if (!visited_q[i_q[IW-1:0]] &&
              (best_q == CW'(ME) || rd_ent_q.bytes > best_bytes_q)) begin
            best_q <= i_q;
            best_bytes_q <= rd_ent_q.bytes;
            best_ent_q <= rd_ent_q;
          end
          i_q <= last_n ? '0 : i_q + 1'b1;
          g_q <= '0;
        end
        lagalloc_pkg::StGrp: begin
          i_q <= '0;
          ok_q <= 1'b1;
        end
        lagalloc_pkg::StScanRd: begin
          if (visited_q[i_q[IW-1:0]] && CW'(rd_grp_q) == g_q && (overlap || !compat))
            ok_q <= 1'b0;
          i_q <= last_n ? '0 : i_q + 1'b1;
        end
        lagalloc_pkg::StPlace: begin
          if (!ok_q && g_q != groups_q) begin
            g_q <= g_q + 1'b1;
          end else begin
            if (g_q == groups_q) groups_q <= groups_q + 1'b1;
            visited_q[best_q[IW-1:0]] <= 1'b1;
            k_q <= k_q + 1'b1;
            best_q <= CW'(ME);
            i_q <= '0;
          end
        end
        lagalloc_pkg::StOut: begin
          out_v_q <= 1'b1;
          out_q.res_index <= i_q[IW-1:0];
          out_q.last_result <= last_n;
          out_q.dropped_any <= ovf_q;
          if (cfg_i.enable_aliasing) begin
            out_q.group_index <= rd_grp_q;
            out_q.group_bytes <= rd_gmax_q;
          end else begin
            out_q.group_index <= i_q[IW-1:0];
            out_q.group_bytes <= rd_ent_q.bytes;
          end
        end
        lagalloc_pkg::StWait: begin
          if (!out_v_q || !out_stall_i) begin
            out_v_q <= 1'b0;
            if (last_n) begin
              cnt_q <= '0;
              ovf_q <= 1'b0;
              i_q <= '0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/lifetime_alias_group_allocator.sv]
`timescale 1ns / 1ps
// channel | direction | handshake           | word
// in      | input     | in_valid_i/in_stall_o   | lagalloc_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i | lagalloc_pkg::out_word_t
// cfg     | input     | apb psel/penable/pwrite | 64-bit register at 8*i
// a declaration is loaded, sized by a two-step multiply and stored; with aliasing on
// the final word runs the placement walk: per resource it picks the largest unplaced
// entry, tests each group in turn and opens a new group if none fits, one entry read per
// cycle; then result words one at a time (entry, group, group size, handoff), each held
// while out stalls; in_stall_o is high from an accept until the word is stored or the
// batch has drained; reset clears control state only, the memories need no clearing
module lifetime_alias_group_allocator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lagalloc_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lagalloc_pkg::out_word_t out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  lagalloc_pkg::cfg_t cfg;

  // register file
  lagalloc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // store, placement walk and result stream
  lagalloc_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;

  // one stored resource as the predictor sees it
  typedef struct {
    logic [39:0] bytes;
    logic [3:0]  kind;
    logic [15:0] fmt;
    logic [31:0] dims;
    logic [11:0] first_use;
    logic [11:0] last_use;
  } resource_t;

  int mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // alias-group predictor and store of expected result words
  class alias_scoreboard;
    resource_t   res[$];
    bit          overflow;
    lagalloc_pkg::cfg_t        cfg;
    lagalloc_pkg::out_word_t   pending[$];

    function new();
      cfg = '{enable_aliasing: 1'b1, require_same_type: 1'b1,
              require_same_format: 1'b0, require_same_dims: 1'b0,
              min_share_bytes: 40'd0};
    endfunction

    function bit can_share(resource_t a, resource_t b);
      if (!(a.last_use < b.first_use || b.last_use < a.first_use)) return 0;
      if (cfg.require_same_type && a.kind != b.kind) return 0;
      if (cfg.require_same_format && a.fmt != b.fmt) return 0;
      if (cfg.require_same_dims && a.dims != b.dims) return 0;
      if (a.bytes < cfg.min_share_bytes || b.bytes < cfg.min_share_bytes) return 0;
      return 1;
    endfunction

    function void note_declaration(lagalloc_pkg::in_word_t w);
      resource_t r;
      logic [63:0] prod;
      int n, groups, best;
      bit seen[32];
      int grp[32];
      logic [39:0] gmax[32];
      bit ok, placed;
      lagalloc_pkg::out_word_t o;
      if (res.size() >= lagalloc_pkg::MaxEntries) overflow = 1;
      else begin
        r.kind = w.kind; r.first_use = w.first_use; r.last_use = w.last_use;
        if (w.is_image) begin
          prod = 64'(w.img_width) * 64'(w.img_height) * 64'd4 * 64'(w.samples);
          r.bytes = (prod > 64'(Max40)) ? Max40 : prod[39:0];
          r.fmt = w.pixel_format;
          r.dims = {w.img_height, w.img_width};
        end else begin
          r.bytes = w.byte_size; r.fmt = '0; r.dims = '0;
        end
        res = {res, r};
      end
      if (!w.final_decl) return;
      n = res.size();
      if (!cfg.enable_aliasing) begin
        for (int i = 0; i < n; i++) begin
          grp[i] = i; gmax[i] = res[i].bytes;
        end
      end else begin
        groups = 0;
        for (int i = 0; i < n; i++) seen[i] = 0;
        for (int k = 0; k < n; k++) begin
          best = -1;
          for (int i = 0; i < n; i++)
            if (!seen[i] && (best < 0 || res[i].bytes > res[best].bytes)) best = i;
          placed = 0;
          for (int g = 0; g < groups && !placed; g++) begin
            ok = 1;
            for (int i = 0; i < n; i++)
              if (seen[i] && grp[i] == g && !can_share(res[best], res[i])) ok = 0;
            if (ok) begin
              grp[best] = g;
              if (res[best].bytes > gmax[g]) gmax[g] = res[best].bytes;
              placed = 1;
            end
          end
          if (!placed) begin
            grp[best] = groups; gmax[groups] = res[best].bytes; groups++;
          end
          seen[best] = 1;
        end
      end
      for (int i = 0; i < n; i++) begin
        o.res_index = 5'(i); o.group_index = 5'(grp[i]); o.group_bytes = gmax[grp[i]];
        o.last_result = (i == n - 1); o.dropped_any = overflow;
        pending = {pending, o};
      end
      res.delete();
      overflow = 0;
    endfunction

    task check_result(lagalloc_pkg::out_word_t got);
      lagalloc_pkg::out_word_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", got));
        return;
      end
      exp = pending.pop_front();
      if (got.res_index != exp.res_index)
        report_mismatch($sformatf("res_index %0d exp %0d", got.res_index, exp.res_index));
      if (got.group_index != exp.group_index)
        report_mismatch($sformatf("group_index %0d exp %0d res %0d",
                                  got.group_index, exp.group_index, exp.res_index));
      if (got.group_bytes != exp.group_bytes)
        report_mismatch($sformatf("group_bytes %0h exp %0h res %0d",
                                  got.group_bytes, exp.group_bytes, exp.res_index));
      if (got.last_result != exp.last_result)
        report_mismatch($sformatf("last_result res %0d", exp.res_index));
      if (got.dropped_any != exp.dropped_any)
        report_mismatch($sformatf("dropped_any res %0d", exp.res_index));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  lagalloc_pkg::in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  lagalloc_pkg::out_word_t out_data_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  alias_scoreboard sb = new();
  bit long_hold = 0;
  bit hold_req = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  lifetime_alias_group_allocator i_dut (.*);

  // result side: stall pattern, with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= long_hold ? 1'b1 : ($urandom_range(0, 3) == 0);
  end

  // long hold-off, counted here while the sender keeps offering words
  initial begin
    wait (hold_req);
    long_hold = 1;
    repeat (2000) @(posedge clk_i);
    long_hold = 0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    // setup then access phase, registers sit at 8*i
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      lagalloc_pkg::RegEnable: sb.cfg.enable_aliasing = val[0];
      lagalloc_pkg::RegType:   sb.cfg.require_same_type = val[0];
      lagalloc_pkg::RegFormat: sb.cfg.require_same_format = val[0];
      lagalloc_pkg::RegDims:   sb.cfg.require_same_dims = val[0];
      lagalloc_pkg::RegMin:    sb.cfg.min_share_bytes = val[39:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input lagalloc_pkg::in_word_t w);
    in_valid_i <= 1; in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_declaration(w);
    // burst or gap before the next word
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic lagalloc_pkg::in_word_t rand_decl(input bit fin, input bit big);
    lagalloc_pkg::in_word_t w;
    w.is_image = 1'($urandom_range(0, 1));
    w.kind = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 1));
    w.byte_size = big ? {8'($urandom), 32'($urandom)} : 40'($urandom_range(0, 4096));
    w.img_width = big ? 16'($urandom) : 16'($urandom_range(0, 64));
    w.img_height = big ? 16'($urandom) : 16'($urandom_range(0, 64));
    w.pixel_format = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2));
    w.samples = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(1, 4));
    w.first_use = $urandom_range(0, 7) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
    w.last_use = $urandom_range(0, 7) == 0 ? 12'($urandom)
                                           : 12'(w.first_use + $urandom_range(0, 8));
    w.final_decl = fin;
    return w;
  endfunction

  initial begin
    lagalloc_pkg::in_word_t w;
    int nbatch;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, inverted lifetime, saturating image, zero samples
    w = '0; w.is_image = 1; w.img_width = 16'hFFFF; w.img_height = 16'hFFFF;
    w.samples = 7'h7F; w.pixel_format = 16'hFFFF; w.kind = 4'hF;
    w.first_use = 12'hFFF; w.last_use = 12'hFFF;
    send_word(w);
    w = '0; w.is_image = 1; w.img_width = 16'd8; w.img_height = 16'd8; w.samples = 0;
    w.first_use = 12'd9; w.last_use = 12'd2; send_word(w);
    w = '0; w.byte_size = Max40; w.first_use = 0; w.last_use = 0; send_word(w);
    w = '0; w.byte_size = 40'd100; w.first_use = 1; w.last_use = 1; send_word(w);
    w = '0; w.byte_size = 40'd100; w.first_use = 3; w.last_use = 5;
    w.final_decl = 1; send_word(w);
    drain();
    // final word alone: a batch of one
    w = '0; w.final_decl = 1; send_word(w);
    drain();
    // full store, then drops, final dropped too
    for (int i = 0; i < 35; i++) send_word(rand_decl(i == 34, 0));
    drain();

    // several settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(lagalloc_pkg::RegEnable, 64'((ph % 4) != 3));
      write_reg(lagalloc_pkg::RegType, 64'(ph[0]));
      write_reg(lagalloc_pkg::RegFormat, 64'(ph[1]));
      write_reg(lagalloc_pkg::RegDims, 64'(ph[2]));
      write_reg(lagalloc_pkg::RegMin, ph == 5 ? 64'(Max40) : (ph == 6 ? 64'd2000 : 64'd0));
      for (int b = 0; b < 4; b++) begin
        nbatch = (ph == 2 && b == 0) ? 33 : $urandom_range(1, 10);
        if (ph == 4 && b == 1) hold_req = 1;
        for (int i = 0; i < nbatch; i++)
          send_word(rand_decl(i == nbatch - 1, $urandom_range(0, 7) == 0));
      end
      drain();
    end
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

[files.f]
rtl/core/lagalloc_pkg.sv
rtl/core/lagalloc_cfg.sv
rtl/core/lagalloc_core.sv
rtl/core/lifetime_alias_group_allocator.sv
tb/testbench.sv
